@@ src/vdi_pkg.sv @@
// Shared constants, types and hash helpers for the vertex dedup indexer.
package vdi_pkg;

  localparam int NODE_CAPACITY = 4096;
  localparam int TABLE_SLOTS   = 8192;
  localparam int COORD_BITS    = 32;
  localparam int INDEX_BITS    = 12;
  localparam int SLOT_BITS     = $clog2(TABLE_SLOTS);
  localparam int COUNT_BITS    = $clog2(NODE_CAPACITY + 1);

  localparam int HASH_STEPS = 6;
  localparam int STEP_BITS  = 3;

  localparam logic [31:0] MIX_MUL_A = 32'h7FEB352D;
  localparam logic [31:0] MIX_MUL_B = 32'h846CA68B;
  localparam logic [31:0] SEED_Y    = 32'h9E3779B9;
  localparam logic [31:0] SEED_Z    = 32'h85EBCA6B;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
    logic [SLOT_BITS-1:0]  home;
  } vdi_item_t;

  // Closing xor-shift of one mix round.
  function automatic logic [31:0] mix_tail(input logic [31:0] h);
    mix_tail = h ^ (h >> 16);
  endfunction

  // Operand fed to the shared multiplier at a given hash step.
  function automatic logic [31:0] mix_operand(input logic [STEP_BITS-1:0] step,
                                              input logic [31:0] h,
                                              input logic [31:0] x,
                                              input logic [31:0] y,
                                              input logic [31:0] z);
    logic [31:0] a;
    a = 32'd0;
    case (step)
      3'd0: a = x ^ (x >> 16);
      3'd2: begin
        a = mix_tail(h) ^ y ^ SEED_Y;
        a = a ^ (a >> 16);
      end
      3'd4: begin
        a = mix_tail(h) ^ z ^ SEED_Z;
        a = a ^ (a >> 16);
      end
      default: a = h ^ (h >> 15);
    endcase
    mix_operand = a;
  endfunction

endpackage

@@ src/vdi_front.sv @@
// Front end: accepts vertex beats and computes the home slot with one shared multiplier.
module vdi_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [vdi_pkg::COORD_BITS-1:0] in_coord_x,
  input  logic signed [vdi_pkg::COORD_BITS-1:0] in_coord_y,
  input  logic signed [vdi_pkg::COORD_BITS-1:0] in_coord_z,
  output logic                              push_valid,
  input  logic                              push_stall,
  output vdi_pkg::vdi_item_t                push_item
);

  logic                             busy_r;
  logic [vdi_pkg::STEP_BITS-1:0]    step_r;
  logic [31:0]                      h_r;
  logic [vdi_pkg::COORD_BITS-1:0]   x_r, y_r, z_r;
  logic [31:0]                      operand;
  logic [31:0]                      mul_const;
  logic [31:0]                      product;
  logic                             hash_done;
  logic [31:0]                      h_final;

  assign in_stall  = busy_r;
  assign hash_done = (step_r == vdi_pkg::STEP_BITS'(vdi_pkg::HASH_STEPS));

  always_comb begin
    operand   = vdi_pkg::mix_operand(step_r, h_r, 32'(x_r), 32'(y_r), 32'(z_r));
    mul_const = step_r[0] ? vdi_pkg::MIX_MUL_B : vdi_pkg::MIX_MUL_A;
    product   = operand * mul_const;
    h_final   = vdi_pkg::mix_tail(h_r);
  end

  assign push_valid     = busy_r && hash_done;
  assign push_item.x    = x_r;
  assign push_item.y    = y_r;
  assign push_item.z    = z_r;
  assign push_item.home = h_final[vdi_pkg::SLOT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (!busy_r) begin
      if (in_valid) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end
    end else if (!hash_done) begin
      step_r <= step_r + 1'b1;
    end else if (!push_stall) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && in_valid) begin
      x_r <= in_coord_x;
      y_r <= in_coord_y;
      z_r <= in_coord_z;
    end
    if (busy_r && !hash_done) begin
      h_r <= product;
    end
  end

endmodule

@@ src/vdi_queue.sv @@
// Two-entry queue between the hash front end and the probe back end.
module vdi_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_stall,
  input  vdi_pkg::vdi_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_stall,
  output vdi_pkg::vdi_item_t pop_item
);

  vdi_pkg::vdi_item_t entry_r [2];
  logic               wr_ptr_r;
  logic               rd_ptr_r;
  logic [1:0]         count_r;
  logic               do_push;
  logic               do_pop;

  assign push_stall = (count_r == 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_item;
  end

endmodule

@@ src/vdi_back.sv @@
// Back end: clears the slot memory, probes it linearly and issues one result per vertex.
module vdi_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_stall,
  input  vdi_pkg::vdi_item_t                q_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [vdi_pkg::INDEX_BITS-1:0]    out_node_index,
  output logic                              out_is_new,
  output logic                              out_table_full
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_CHECK = 2'd3;

  localparam logic [vdi_pkg::SLOT_BITS-1:0] LAST_SLOT =
    vdi_pkg::SLOT_BITS'(vdi_pkg::TABLE_SLOTS - 1);

  typedef struct packed {
    logic                              valid;
    logic [vdi_pkg::COORD_BITS-1:0]    x;
    logic [vdi_pkg::COORD_BITS-1:0]    y;
    logic [vdi_pkg::COORD_BITS-1:0]    z;
    logic [vdi_pkg::INDEX_BITS-1:0]    index;
  } slot_t;

  slot_t mem [vdi_pkg::TABLE_SLOTS];

  logic [1:0]                        state_r, state_nxt;
  logic [vdi_pkg::SLOT_BITS-1:0]     addr_r, addr_nxt;
  logic [vdi_pkg::SLOT_BITS:0]       probe_r, probe_nxt;
  logic [vdi_pkg::COUNT_BITS-1:0]    cnt_r, cnt_nxt;
  vdi_pkg::vdi_item_t                item_r;
  slot_t                             rd_r;
  logic                              load_item;
  logic                              we;
  logic                              re;
  slot_t                             wdata;
  logic                              hit;
  logic                              out_valid_r, out_valid_nxt;
  logic [vdi_pkg::INDEX_BITS-1:0]    out_index_r, out_index_nxt;
  logic                              out_new_r, out_new_nxt;
  logic                              out_full_r, out_full_nxt;
  logic                              out_free;

  assign out_valid      = out_valid_r;
  assign out_node_index = out_index_r;
  assign out_is_new     = out_new_r;
  assign out_table_full = out_full_r;

  assign out_free = !out_valid_r || !out_stall;
  assign hit = rd_r.valid && (rd_r.x == item_r.x) && (rd_r.y == item_r.y) &&
               (rd_r.z == item_r.z);

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    probe_nxt     = probe_r;
    cnt_nxt       = cnt_r;
    load_item     = 1'b0;
    q_stall       = 1'b1;
    we            = 1'b0;
    re            = 1'b0;
    wdata         = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_index_nxt = out_index_r;
    out_new_nxt   = out_new_r;
    out_full_nxt  = out_full_r;

    unique case (state_r)
      ST_CLEAR: begin
        we = 1'b1;
        if (addr_r == LAST_SLOT) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_stall   = 1'b0;
          load_item = 1'b1;
          addr_nxt  = q_item.home;
          probe_nxt = '0;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        re        = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!rd_r.valid) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (cnt_r < vdi_pkg::COUNT_BITS'(vdi_pkg::NODE_CAPACITY)) begin
            we            = 1'b1;
            wdata.valid   = 1'b1;
            wdata.x       = item_r.x;
            wdata.y       = item_r.y;
            wdata.z       = item_r.z;
            wdata.index   = cnt_r[vdi_pkg::INDEX_BITS-1:0];
            cnt_nxt       = cnt_r + 1'b1;
            out_index_nxt = cnt_r[vdi_pkg::INDEX_BITS-1:0];
            out_new_nxt   = 1'b1;
            out_full_nxt  = 1'b0;
          end else begin
            out_index_nxt = '0;
            out_new_nxt   = 1'b0;
            out_full_nxt  = 1'b1;
          end
        end else if (hit) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = rd_r.index;
          out_new_nxt   = 1'b0;
          out_full_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end else if (probe_r == (vdi_pkg::SLOT_BITS + 1)'(vdi_pkg::TABLE_SLOTS - 1)) begin
          // Every slot has been visited without a match or a hole.
          out_valid_nxt = 1'b1;
          out_index_nxt = '0;
          out_new_nxt   = 1'b0;
          out_full_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          addr_nxt  = (addr_r == LAST_SLOT) ? '0 : addr_r + 1'b1;
          probe_nxt = probe_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    probe_r     <= probe_nxt;
    out_index_r <= out_index_nxt;
    out_new_r   <= out_new_nxt;
    out_full_r  <= out_full_nxt;
    if (load_item) item_r <= q_item;
  end

  // Slot memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[addr_r] <= wdata;
    if (re) rd_r <= mem[addr_r];
  end

endmodule

@@ src/vertex_dedup_indexer.sv @@
// Top level of the vertex dedup indexer: hash front end, queue and probe back end.
//
//   channel | direction | ports
//   --------+-----------+---------------------------------------------------
//   in      | input     | in_valid, in_stall, in_coord_x/y/z
//   out     | output    | out_valid, out_stall, out_node_index, out_is_new,
//           |           | out_table_full
//
// The front end takes one vertex at a time: accept, six multiply steps and the push.
// The back end takes one vertex at a time, with a read and a check state per probe.
// After reset all 8192 slots of the slot memory are cleared before the first probe.
// The two-entry queue lets hashing continue while the back end or the output stalls.
module vertex_dedup_indexer (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [vdi_pkg::COORD_BITS-1:0] in_coord_x,
  input  logic signed [vdi_pkg::COORD_BITS-1:0] in_coord_y,
  input  logic signed [vdi_pkg::COORD_BITS-1:0] in_coord_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [vdi_pkg::INDEX_BITS-1:0]        out_node_index,
  output logic                                  out_is_new,
  output logic                                  out_table_full
);

  logic               push_valid, push_stall;
  vdi_pkg::vdi_item_t push_item;
  logic               q_valid, q_stall;
  vdi_pkg::vdi_item_t q_item;

  vdi_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_coord_x (in_coord_x),
    .in_coord_y (in_coord_y),
    .in_coord_z (in_coord_z),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_item  (push_item)
  );

  vdi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop_stall  (q_stall),
    .pop_item   (q_item)
  );

  vdi_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_stall        (q_stall),
    .q_item         (q_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_node_index (out_node_index),
    .out_is_new     (out_is_new),
    .out_table_full (out_table_full)
  );

endmodule

@@ src/vdi_checker.sv @@
// Port-level checks for the vertex dedup indexer, bound to the top level.
module vdi_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [vdi_pkg::INDEX_BITS-1:0] out_node_index,
  input logic                           out_is_new,
  input logic                           out_table_full
);

  // A result is never both a fresh entry and a rejection.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_new && out_table_full))
    else $error("result flagged both new and full");

  // A rejected vertex always reports index zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> (out_node_index == '0))
    else $error("full result with nonzero index");

  // No result beat is pending right after reset.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result beat holds its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_node_index) &&
                                  $stable(out_is_new) && $stable(out_table_full)))
    else $error("stalled result changed");

endmodule

bind vertex_dedup_indexer vdi_checker u_vdi_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_node_index (out_node_index),
  .out_is_new     (out_is_new),
  .out_table_full (out_table_full)
);

@@ dv/vertex_dedup_indexer_tb.sv @@
// Testbench for the vertex dedup indexer: directed and random vertex streams checked by a predictor.
module vertex_dedup_indexer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 900000;

  typedef struct packed {
    logic [vdi_pkg::INDEX_BITS-1:0] node_index;
    logic                           is_new;
    logic                           table_full;
  } lookup_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [vdi_pkg::COORD_BITS-1:0] in_coord_x, in_coord_y, in_coord_z;
  logic out_valid;
  logic out_stall;
  logic [vdi_pkg::INDEX_BITS-1:0] out_node_index;
  logic out_is_new;
  logic out_table_full;

  vertex_dedup_indexer dut (.*);

  // Predictor state: a mirror of the hash table.
  bit                           tbl_used [vdi_pkg::TABLE_SLOTS];
  bit [31:0]                    tbl_x [vdi_pkg::TABLE_SLOTS];
  bit [31:0]                    tbl_y [vdi_pkg::TABLE_SLOTS];
  bit [31:0]                    tbl_z [vdi_pkg::TABLE_SLOTS];
  bit [vdi_pkg::INDEX_BITS-1:0] tbl_idx [vdi_pkg::TABLE_SLOTS];
  int unsigned                  stored_count;

  lookup_t     pending_lookups[$];
  int unsigned errors;
  int unsigned beats_out;
  int unsigned cycle_count;
  int unsigned new_seen, full_seen, hit_seen;
  bit          idle_free;
  bit          hold_off;
  bit [31:0]   hist_x[$], hist_y[$], hist_z[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit [31:0] mix32(bit [31:0] h);
    h ^= h >> 16;
    h *= 32'h7FEB352D;
    h ^= h >> 15;
    h *= 32'h846CA68B;
    h ^= h >> 16;
    return h;
  endfunction

  function automatic lookup_t dedup_lookup(bit [31:0] x, bit [31:0] y, bit [31:0] z);
    bit [31:0] h;
    int unsigned pos;
    lookup_t r;
    h = mix32(x);
    h = mix32(h ^ y ^ 32'h9E3779B9);
    h = mix32(h ^ z ^ 32'h85EBCA6B);
    pos = h % vdi_pkg::TABLE_SLOTS;
    r = '0;
    for (int p = 0; p < vdi_pkg::TABLE_SLOTS; p++) begin
      if (!tbl_used[pos]) begin
        if (stored_count < vdi_pkg::NODE_CAPACITY) begin
          tbl_used[pos] = 1'b1;
          tbl_x[pos] = x;
          tbl_y[pos] = y;
          tbl_z[pos] = z;
          tbl_idx[pos] = stored_count[vdi_pkg::INDEX_BITS-1:0];
          r.node_index = stored_count[vdi_pkg::INDEX_BITS-1:0];
          r.is_new = 1'b1;
          stored_count++;
        end else begin
          r.table_full = 1'b1;
        end
        return r;
      end
      if (tbl_x[pos] == x && tbl_y[pos] == y && tbl_z[pos] == z) begin
        r.node_index = tbl_idx[pos];
        return r;
      end
      pos = (pos + 1) % vdi_pkg::TABLE_SLOTS;
    end
    r.table_full = 1'b1;
    return r;
  endfunction

  // Result checker and receiver-side stalls.
  always @(posedge clk) begin
    lookup_t want;
    if (rst_n && out_valid && !out_stall) begin
      beats_out++;
      if (pending_lookups.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual idx=%0d new=%0b full=%0b",
                 $time, out_node_index, out_is_new, out_table_full);
      end else begin
        want = pending_lookups.pop_front();
        if (out_node_index !== want.node_index) begin
          errors++;
          $display("%0t: node_index expected %0d actual %0d", $time, want.node_index,
                   out_node_index);
        end
        if (out_is_new !== want.is_new) begin
          errors++;
          $display("%0t: is_new expected %0b actual %0b", $time, want.is_new, out_is_new);
        end
        if (out_table_full !== want.table_full) begin
          errors++;
          $display("%0t: table_full expected %0b actual %0b", $time, want.table_full,
                   out_table_full);
        end
        if (want.is_new) new_seen++;
        else if (want.table_full) full_seen++;
        else hit_seen++;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= hold_off || (!idle_free && $urandom_range(99) < 21);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Valid stays high after an accepted beat until the next beat or an idle cycle replaces it.
  task automatic send_vertex(bit [31:0] x, bit [31:0] y, bit [31:0] z);
    while (!idle_free && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    pending_lookups = {pending_lookups, dedup_lookup(x, y, z)};
    hist_x = {hist_x, x};
    hist_y = {hist_y, y};
    hist_z = {hist_z, z};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_extremes();
    bit [31:0] v[4] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    for (int i = 0; i < 4; i++) send_vertex(v[i], v[(i + 1) % 4], v[(i + 2) % 4]);
    send_vertex(v[0], v[1], v[2]);
    send_vertex(v[1], v[2], v[3]);
    for (int i = 0; i < 4; i++) send_vertex(v[i], v[i], v[i]);
    send_vertex(v[3], v[3], v[3]);
    drain_results();
  endtask

  task automatic test_random_mix(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 40 && hist_x.size() != 0) begin
        k = $urandom_range(hist_x.size() - 1);
        send_vertex(hist_x[k], hist_y[k], hist_z[k]);
      end else begin
        send_vertex($urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random_mix(40);
    join
    drain_results();
  endtask

  task automatic test_no_idle();
    idle_free = 1'b1;
    test_random_mix(200);
    idle_free = 1'b0;
    drain_results();
  endtask

  // Alternate fresh vertices with revisits of known ones.
  task automatic test_revisit();
    int k;
    for (int i = 0; i < 200; i++) begin
      if (i % 2 == 0) begin
        send_vertex($urandom, $urandom, $urandom);
      end else begin
        k = $urandom_range(hist_x.size() - 1);
        send_vertex(hist_x[k], hist_y[k], hist_z[k]);
      end
    end
    drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_coord_x = '0;
    in_coord_y = '0;
    in_coord_z = '0;
    out_stall = 1'b0;
    hold_off = 1'b0;
    idle_free = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_backpressure();
    test_no_idle();
    test_random_mix(1100);
    drain_results();
    test_revisit();
    repeat (50) @(posedge clk);
    $display("Checked %0d result beats: %0d new, %0d repeats, %0d rejected as full.",
             beats_out, new_seen, hit_seen, full_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
src/vdi_pkg.sv
src/vdi_front.sv
src/vdi_queue.sv
src/vdi_back.sv
src/vertex_dedup_indexer.sv
src/vdi_checker.sv
dv/vertex_dedup_indexer_tb.sv
